[rtl/d8_flow_accumulation_macros.svh]
// Assertion macros shared by the flow accumulation RTL.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef D8_FLOW_ACCUMULATION_MACROS_SVH
`define D8_FLOW_ACCUMULATION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define D8FA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("d8fa assertion failed");
// Next-cycle implication.
`define D8FA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("d8fa assertion failed");
`else
`define D8FA_ASSERT_NOW(lbl, ante, cons)
`define D8FA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/d8fa_pkg.sv]
`timescale 1ns / 1ps
package d8fa_pkg;

  localparam int GRID_ROWS  = 256;
  localparam int GRID_COLS  = 256;
  localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);

  localparam int COORD_W     = 8;
  localparam int AREA_W      = 48;
  localparam int CELL_AREA_W = 24;
  localparam int DIR_W       = 4;
  localparam int STATUS_W    = 2;

  localparam logic [AREA_W-1:0]      AREA_MAX        = '1;
  localparam logic [CELL_AREA_W-1:0] CELL_AREA_RESET = CELL_AREA_W'(1);

  localparam logic [DIR_W-1:0] DIR_MIN    = DIR_W'(1);
  localparam logic [DIR_W-1:0] DIR_OUTLET = DIR_W'(5);
  localparam logic [DIR_W-1:0] DIR_MAX    = DIR_W'(9);

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DIR   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OFF_GRID  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

  // Signed coordinate with room for one step either side of the 8-bit range.
  typedef logic signed [COORD_W+1:0] coord_ext_t;
  typedef logic signed [1:0]         step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // write zero to the next entry of the clearing pass
    logic take;       // accept a cell and read its own entry
    logic rd_nbr;     // register the own sum and read the neighbour entry
    logic fin_err;    // load an error result
    logic fin_own;    // write the outlet entry and load its result
    logic fin_nbr;    // write the neighbour entry and load its result
  } d8fa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // clearing pass is at its last entry
    logic reject;     // latched cell has a bad direction or is off the grid
    logic outlet;     // latched cell drains into itself
    logic out_free;   // result register can take a new result
  } d8fa_sts_t;

  // Keypad row step: top row of the keypad points one row up.
  function automatic step_t row_step(input logic [DIR_W-1:0] dir);
    step_t s;
    case (dir) inside
      4'd1, 4'd2, 4'd3: s = 2'sd1;
      4'd7, 4'd8, 4'd9: s = -2'sd1;
      default:          s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic step_t col_step(input logic [DIR_W-1:0] dir);
    step_t s;
    case (dir) inside
      4'd1, 4'd4, 4'd7: s = -2'sd1;
      4'd3, 4'd6, 4'd9: s = 2'sd1;
      default:          s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/d8fa_cell_if.sv]
`timescale 1ns / 1ps
interface d8fa_cell_if;
  import d8fa_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cell_row;
  logic [COORD_W-1:0] cell_col;
  logic [DIR_W-1:0]   flow_direction;

  modport source (output valid, output cell_row, output cell_col,
                  output flow_direction, input ready);
  modport sink (input valid, input cell_row, input cell_col,
                input flow_direction, output ready);
endinterface

[rtl/d8fa_result_if.sv]
`timescale 1ns / 1ps
interface d8fa_result_if;
  import d8fa_pkg::*;

  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  target_row;
  logic [COORD_W-1:0]  target_col;
  logic [AREA_W-1:0]   target_area;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output target_row, output target_col,
                  output target_area, output status, input ready);
  modport sink (input valid, input target_row, input target_col,
                input target_area, input status, output ready);
endinterface

[rtl/d8fa_ram.sv]
`timescale 1ns / 1ps
module d8fa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/d8fa_ctrl.sv]
`timescale 1ns / 1ps
`include "d8_flow_accumulation_macros.svh"
module d8fa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  d8fa_pkg::d8fa_sts_t sts,
  output d8fa_pkg::d8fa_cmd_t cmd
);
  import d8fa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SUM   = 2'd2;
  localparam logic [1:0] S_ADD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (sts.reject) begin
          if (sts.out_free) begin
            cmd.fin_err = 1'b1;
            state_next  = S_IDLE;
          end
        end else if (sts.outlet) begin
          if (sts.out_free) begin
            cmd.fin_own = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.rd_nbr = 1'b1;
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.fin_nbr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `D8FA_ASSERT_NOW(a_fin_needs_room, cmd.fin_err || cmd.fin_own || cmd.fin_nbr, sts.out_free)
  `D8FA_ASSERT_NOW(a_one_writer, 1'b1, $onehot0({cmd.clr_step, cmd.fin_own, cmd.fin_nbr}))
  `D8FA_ASSERT_NEXT(a_take_then_sum, cmd.take, state == S_SUM)

endmodule

[rtl/d8fa_datapath.sv]
`timescale 1ns / 1ps
`include "d8_flow_accumulation_macros.svh"
module d8fa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  d8fa_pkg::d8fa_cmd_t                 cmd,
  output d8fa_pkg::d8fa_sts_t                 sts,
  input  logic [d8fa_pkg::COORD_W-1:0]        cell_row,
  input  logic [d8fa_pkg::COORD_W-1:0]        cell_col,
  input  logic [d8fa_pkg::DIR_W-1:0]          flow_direction,
  input  logic                                cfg_wr_en,
  input  logic [d8fa_pkg::CELL_AREA_W-1:0]    cfg_wr_data,
  d8fa_result_if.source                       results
);
  import d8fa_pkg::*;

  logic [CELL_AREA_W-1:0] cell_area;

  // Neighbour and range checks on the incoming cell.
  coord_ext_t        row_ext, col_ext, nbr_row, nbr_col;
  logic              bad_dir, off_grid;
  logic [ADDR_W-1:0] own_addr_c, nbr_addr_c;

  // Latched cell.
  logic [COORD_W-1:0] row_q, col_q, nbr_row_q, nbr_col_q;
  logic [ADDR_W-1:0]  own_addr_q, nbr_addr_q;
  logic               bad_q, off_q, outlet_q;

  // Sums.
  logic [AREA_W:0]   own_sum_w, nbr_sum_w;
  logic [AREA_W-1:0] own_sum, nbr_val, sum_q;
  logic              own_sat, nbr_sat, sum_sat_q;

  // Grid memory ports and clearing pass.
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr, clr_addr;
  logic [AREA_W-1:0] wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_area <= CELL_AREA_RESET;
    end else if (cfg_wr_en) begin
      cell_area <= cfg_wr_data;
    end
  end

  always_comb begin
    row_ext    = coord_ext_t'({2'b00, cell_row});
    col_ext    = coord_ext_t'({2'b00, cell_col});
    nbr_row    = row_ext + coord_ext_t'(row_step(flow_direction));
    nbr_col    = col_ext + coord_ext_t'(col_step(flow_direction));
    bad_dir    = (flow_direction < DIR_MIN) || (flow_direction > DIR_MAX);
    off_grid   = (int'(cell_row) >= GRID_ROWS) || (int'(cell_col) >= GRID_COLS) ||
                 (nbr_row < 0) || (nbr_col < 0) ||
                 (int'(nbr_row) >= GRID_ROWS) || (int'(nbr_col) >= GRID_COLS);
    own_addr_c = ADDR_W'(int'(cell_row) * GRID_COLS + int'(cell_col));
    nbr_addr_c = ADDR_W'(int'(nbr_row) * GRID_COLS + int'(nbr_col));
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_q      <= cell_row;
      col_q      <= cell_col;
      nbr_row_q  <= nbr_row[COORD_W-1:0];
      nbr_col_q  <= nbr_col[COORD_W-1:0];
      own_addr_q <= own_addr_c;
      nbr_addr_q <= nbr_addr_c;
      bad_q      <= bad_dir;
      off_q      <= off_grid;
      outlet_q   <= (flow_direction == DIR_OUTLET);
    end
    if (cmd.rd_nbr) begin
      sum_q     <= own_sum;
      sum_sat_q <= own_sat;
    end
  end

  always_comb begin
    own_sum_w = {1'b0, rd_data} + (AREA_W+1)'(cell_area);
    own_sat   = own_sum_w[AREA_W];
    own_sum   = own_sat ? AREA_MAX : own_sum_w[AREA_W-1:0];
    nbr_sum_w = {1'b0, rd_data} + {1'b0, sum_q};
    nbr_sat   = nbr_sum_w[AREA_W];
    nbr_val   = nbr_sat ? AREA_MAX : nbr_sum_w[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    wr_en   = cmd.clr_step | cmd.fin_own | cmd.fin_nbr;
    wr_addr = cmd.clr_step ? clr_addr : (cmd.fin_own ? own_addr_q : nbr_addr_q);
    wr_data = cmd.fin_own ? own_sum : (cmd.fin_nbr ? nbr_val : '0);
    rd_en   = cmd.take | cmd.rd_nbr;
    rd_addr = cmd.take ? own_addr_c : nbr_addr_q;
  end

  d8fa_ram #(
    .WIDTH (AREA_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.fin_err || cmd.fin_own || cmd.fin_nbr) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_err) begin
      results.target_row  <= row_q;
      results.target_col  <= col_q;
      results.target_area <= '0;
      results.status      <= bad_q ? ST_BAD_DIR : ST_OFF_GRID;
    end else if (cmd.fin_own) begin
      results.target_row  <= row_q;
      results.target_col  <= col_q;
      results.target_area <= own_sum;
      results.status      <= own_sat ? ST_SATURATED : ST_OK;
    end else if (cmd.fin_nbr) begin
      results.target_row  <= nbr_row_q;
      results.target_col  <= nbr_col_q;
      results.target_area <= nbr_val;
      results.status      <= (sum_sat_q || nbr_sat) ? ST_SATURATED : ST_OK;
    end
  end

  always_comb begin
    sts.clr_last = (clr_addr == ADDR_W'(GRID_DEPTH - 1));
    sts.reject   = bad_q | off_q;
    sts.outlet   = outlet_q;
    sts.out_free = !results.valid || results.ready;
  end

  `D8FA_ASSERT_NEXT(a_fin_shows_result, cmd.fin_err || cmd.fin_own || cmd.fin_nbr, results.valid)
  `D8FA_ASSERT_NEXT(a_result_held, results.valid && !results.ready, results.valid)
  `D8FA_ASSERT_NOW(a_no_result_in_clear, cmd.clr_step, !results.valid)

endmodule

[rtl/d8_flow_accumulation.sv]
`timescale 1ns / 1ps
// A rejected or outlet cell has its result loaded in S_SUM, and a cell that drains into a
// neighbour in S_ADD, after the neighbour read; a load waits until the last result is taken.
// A new cell is accepted only once the previous cell's result is loaded, as the grid memory
// has a single read port (own read, neighbour read, then write-back).
// Reset: synchronous; cell_area returns to 1 and a clearing pass zeroes the grid.
module d8_flow_accumulation (
  input  logic                             clk,
  input  logic                             rst,
  d8fa_cell_if.sink                        cells,
  d8fa_result_if.source                    results,
  input  logic                             cfg_wr_en,
  input  logic [d8fa_pkg::CELL_AREA_W-1:0] cfg_wr_data
);
  import d8fa_pkg::*;

  // The block is split into a small controller, which sequences the memory
  // accesses for each cell, and a datapath, which owns the grid memory, the
  // cell area register, the saturating adders and the result register.
  //
  // Each transaction on the cell channel is handled in a few steps:
  //   1. On acceptance the cell's own entry is read, and the neighbour
  //      coordinates, grid addresses and error checks are registered.
  //   2. The own area plus cell_area is formed with saturation. For an
  //      outlet this sum is written back into the cell's own entry and
  //      becomes the result; otherwise the neighbour entry is read.
  //   3. The neighbour area plus the sum is formed with saturation, written
  //      back, and becomes the result.
  // A rejected cell (bad direction, or itself or its neighbour off the grid)
  // writes nothing and yields an error result carrying the input coordinates.
  //
  // The result register decouples the two channels: a new cell is accepted
  // while an earlier result still waits, and the controller only holds
  // before loading the next result if the previous one has not been taken.
  //
  // After reset the grid memory is swept once, one entry per cycle, writing
  // zeros; no cell transaction is accepted until that pass is complete.
  // Configuration writes are taken at any time during the pass.

  d8fa_cmd_t cmd;
  d8fa_sts_t sts;

  d8fa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cells.valid),
    .in_ready (cells.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  d8fa_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cell_row       (cells.cell_row),
    .cell_col       (cells.cell_col),
    .flow_direction (cells.flow_direction),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .results        (results)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import d8fa_pkg::*;

  // Keypad codes for the eight neighbours and the outlet. Code zero and
  // everything above the top of the keypad are invalid directions.
  typedef enum logic [DIR_W-1:0] {
    KP_NONE   = 4'd0,
    KP_SW     = 4'd1,
    KP_S      = 4'd2,
    KP_SE     = 4'd3,
    KP_W      = 4'd4,
    KP_OUTLET = 4'd5,
    KP_E      = 4'd6,
    KP_NW     = 4'd7,
    KP_N      = 4'd8,
    KP_NE     = 4'd9
  } keypad_t;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [AREA_W-1:0]   area;
    logic [STATUS_W-1:0] status;
  } flow_result_t;

  // The scoreboard keeps its own copy of the accumulation grid and of the
  // cell area register. Every accepted cell queues the result which the
  // block ought to produce for it, and updates that copy unless rejected.
  class flow_scoreboard;
    bit [AREA_W-1:0]      area_grid [GRID_DEPTH];
    bit [CELL_AREA_W-1:0] cell_area;
    flow_result_t         expected_q [$];
    int unsigned          errors;
    int unsigned          checked;

    function new();
      foreach (area_grid[i]) area_grid[i] = '0;
      cell_area = CELL_AREA_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    static function int row_delta(logic [DIR_W-1:0] dir);
      case (dir)
        KP_SW, KP_S, KP_SE: return 1;
        KP_NW, KP_N, KP_NE: return -1;
        default:            return 0;
      endcase
    endfunction

    static function int col_delta(logic [DIR_W-1:0] dir);
      case (dir)
        KP_SW, KP_W, KP_NW: return -1;
        KP_SE, KP_E, KP_NE: return 1;
        default:            return 0;
      endcase
    endfunction

    // Adds with a clamp at the largest area; sat is left set once a clamp hits.
    function bit [AREA_W-1:0] clamp_add(bit [AREA_W-1:0] a, bit [AREA_W-1:0] b,
                                        inout bit sat);
      bit [AREA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[AREA_W]) begin
        sat = 1'b1;
        return AREA_MAX;
      end
      return s[AREA_W-1:0];
    endfunction

    function void set_cell_area(logic [CELL_AREA_W-1:0] value);
      cell_area = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_cell(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                            logic [DIR_W-1:0] dir);
      flow_result_t    want;
      int              nr, nc, own, tgt;
      bit              sat;
      bit [AREA_W-1:0] sum;
      want = '{row: row, col: col, area: '0, status: ST_OK};
      sat  = 1'b0;
      if (dir < DIR_MIN || dir > DIR_MAX) begin
        want.status = ST_BAD_DIR;
      end else begin
        nr = int'(row) + row_delta(dir);
        nc = int'(col) + col_delta(dir);
        if (nr < 0 || nc < 0 || nr >= GRID_ROWS || nc >= GRID_COLS) begin
          want.status = ST_OFF_GRID;
        end else begin
          own = int'(row) * GRID_COLS + int'(col);
          sum = clamp_add(area_grid[own], AREA_W'(cell_area), sat);
          if (dir == KP_OUTLET) begin
            area_grid[own] = sum;
            want.area      = sum;
          end else begin
            tgt            = nr * GRID_COLS + nc;
            area_grid[tgt] = clamp_add(area_grid[tgt], sum, sat);
            want.row       = COORD_W'(nr);
            want.col       = COORD_W'(nc);
            want.area      = area_grid[tgt];
          end
          if (sat) want.status = ST_SATURATED;
        end
      end
      expected_q.push_back(want);
    endfunction

    function void report(string field, logic [AREA_W-1:0] want, logic [AREA_W-1:0] got);
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(flow_result_t got);
      flow_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: result with nothing expected, actual row %0h col %0h area %0h st %0h",
                   $time, got.row, got.col, got.area, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.row !== want.row)       report("target_row", want.row, got.row);
      if (got.col !== want.col)       report("target_col", want.col, got.col);
      if (got.area !== want.area)     report("target_area", want.area, got.area);
      if (got.status !== want.status) report("status", want.status, got.status);
    endfunction
  endclass

  // Clock and the block's inputs all hold known values from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CELL_AREA_W-1:0] cfg_wr_data = '0;

  d8fa_cell_if   cells_if ();
  d8fa_result_if results_if ();

  flow_scoreboard sb = new();

  // Cells with a valid direction that have been accepted so far; the random
  // phases count these and ignore the bad-direction noise.
  int unsigned valid_cells = 0;
  // While set, the sender offers cells back to back with no idle cycles.
  bit          sender_quiet = 1'b0;

  always #5 clk = ~clk;

  d8_flow_accumulation dut (
    .clk         (clk),
    .rst         (rst),
    .cells       (cells_if),
    .results     (results_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Idle stretches are mostly short, with the odd long one.
  function automatic int unsigned gap_cycles(bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinates favour the borders and a small central patch, so that the
  // same entries are revisited and the neighbour checks at the edges are hit.
  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return COORD_W'($urandom_range(255));
    if (roll < 60) return COORD_W'($urandom_range(7));
    if (roll < 80) return COORD_W'($urandom_range(248, 255));
    return COORD_W'($urandom_range(120, 135));
  endfunction

  // Offers one cell and holds it until the block takes it. Every call starts
  // on a rising edge and returns on the edge at which the transaction was
  // accepted, with valid still high, so that the next offer can follow on
  // without valid being lowered and raised in the same time step.
  task automatic send_cell(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                           input logic [DIR_W-1:0] dir);
    cells_if.valid          <= 1'b1;
    cells_if.cell_row       <= row;
    cells_if.cell_col       <= col;
    cells_if.flow_direction <= dir;
    do @(posedge clk); while (!cells_if.ready);
    sb.note_cell(row, col, dir);
    if (dir >= DIR_MIN && dir <= DIR_MAX) valid_cells++;
  endtask

  // A random idle gap on the input side, then the cell itself.
  task automatic offer(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                       input logic [DIR_W-1:0] dir);
    int unsigned n;
    n = gap_cycles(sender_quiet);
    if (n > 0) begin
      cells_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    send_cell(row, col, dir);
  endtask

  // Two neighbouring cells that drain into each other in turn. Each pass adds
  // the whole of the other entry, so the areas grow roughly like a Fibonacci
  // series and soon reach the clamp when the cell area is large.
  task automatic pingpong(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                          input logic [DIR_W-1:0] dir, input int unsigned len);
    logic [COORD_W-1:0] nrow, ncol;
    nrow = COORD_W'(int'(row) + flow_scoreboard::row_delta(dir));
    ncol = COORD_W'(int'(col) + flow_scoreboard::col_delta(dir));
    for (int unsigned i = 0; i < len; i++) begin
      if (i % 2 == 0) offer(row, col, dir);
      else offer(nrow, ncol, DIR_W'(DIR_MAX + DIR_MIN - dir));
    end
  endtask

  // The register is only written once the block has gone quiet: every
  // expected result has arrived and a few more cycles have passed.
  task automatic write_cell_area(input logic [CELL_AREA_W-1:0] value);
    cells_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_cell_area(value);
  endtask

  // Random traffic, mostly well-formed downstream walks and drain loops with
  // random content, plus border cells and raw noise over every field value.
  task automatic random_phase(input int unsigned target);
    int unsigned        start, kind, len;
    logic [COORD_W-1:0] row, col;
    logic [DIR_W-1:0]   dir;
    int                 nr, nc;
    start = valid_cells;
    while (valid_cells - start < target) begin
      sender_quiet = ($urandom_range(99) < 15);
      kind = $urandom_range(99);
      if (kind < 45) begin
        // Walk downstream from a start cell, following each neighbour.
        row = pick_coord();
        col = pick_coord();
        len = $urandom_range(3, 12);
        repeat (len) begin
          dir = DIR_W'($urandom_range(DIR_MIN, DIR_MAX));
          offer(row, col, dir);
          nr = int'(row) + flow_scoreboard::row_delta(dir);
          nc = int'(col) + flow_scoreboard::col_delta(dir);
          if (nr < 0 || nc < 0 || nr >= GRID_ROWS || nc >= GRID_COLS) break;
          row = COORD_W'(nr);
          col = COORD_W'(nc);
        end
      end else if (kind < 60) begin
        do dir = DIR_W'($urandom_range(DIR_MIN, DIR_MAX)); while (dir == KP_OUTLET);
        pingpong(COORD_W'($urandom_range(1, 254)), COORD_W'($urandom_range(1, 254)), dir,
                 $urandom_range(4, 60));
      end else if (kind < 75) begin
        // Cells near the corners, on the outermost two rings, where many neighbours fall off.
        repeat ($urandom_range(1, 4)) begin
          row = COORD_W'($urandom_range(1));
          if ($urandom_range(1)) row = ~row;
          col = COORD_W'($urandom_range(1));
          if ($urandom_range(1)) col = ~col;
          offer(row, col, DIR_W'($urandom_range(DIR_MIN, DIR_MAX)));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          offer(COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                DIR_W'($urandom_range(15)));
      end
    end
    sender_quiet = 1'b0;
  endtask

  // Result side: checks every accepted result transaction and drives ready
  // with random stalls. Once, after a few hundred results, it holds ready low
  // for a long stretch while the sender keeps offering cells, so that the
  // block backs up and stops taking input.
  initial begin : result_sink
    int unsigned stall_left, quiet_left;
    bit          long_done;
    stall_left = 0;
    quiet_left = 0;
    long_done  = 1'b0;
    results_if.ready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready)
        sb.check_result('{row: results_if.target_row, col: results_if.target_col,
                          area: results_if.target_area, status: results_if.status});
      if (!long_done && sb.checked >= 400) begin
        long_done  = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0) begin
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(99) < 3) quiet_left = $urandom_range(50, 200);
        else stall_left = gap_cycles(1'b0);
      end
      if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, a directed part at a cell area of one, a chase
  // into saturation at the largest, then random phases at several settings.
  initial begin : stimulus
    cells_if.valid          <= 1'b0;
    cells_if.cell_row       <= '0;
    cells_if.cell_col       <= '0;
    cells_if.flow_direction <= KP_NONE;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The block spends a long clearing pass after reset with its input
    // stalled; the first offer simply waits for it.
    write_cell_area(CELL_AREA_RESET);

    // Directed part. The grid starts at zero and each cell that is not rejected adds one unit.
    offer(8'd0, 8'd0, KP_OUTLET);
    offer(8'd0, 8'd0, KP_NW);
    offer(8'd0, 8'd0, KP_SW);
    offer(8'd0, 8'd0, KP_N);
    offer(8'd255, 8'd255, KP_SE);
    offer(8'd255, 8'd255, KP_E);
    offer(8'd255, 8'd0, KP_S);
    offer(8'd0, 8'd255, KP_NE);
    // Invalid keypad codes at either end of the four-bit range.
    offer(8'd255, 8'd255, KP_NONE);
    offer(8'hAA, 8'h55, DIR_W'(4'hF));
    offer(8'd0, 8'd0, DIR_W'(DIR_MAX + 1));
    offer(8'd0, 8'd0, KP_SE);
    // Every direction from one centre cell, the outlet among them.
    for (int d = DIR_MIN; d <= DIR_MAX; d++) offer(8'd128, 8'd128, DIR_W'(d));
    // Corners draining inwards, and a cell that feeds back into the origin.
    offer(8'd255, 8'd255, KP_NW);
    offer(8'd0, 8'd255, KP_SW);
    offer(8'd255, 8'd0, KP_NE);
    offer(8'd1, 8'd1, KP_NW);

    // Largest cell area: a drain loop is driven well past the clamp, then
    // both of its cells are drained as outlets while already clamped.
    write_cell_area({CELL_AREA_W{1'b1}});
    pingpong(8'd200, 8'd200, KP_E, 52);
    offer(8'd200, 8'd200, KP_OUTLET);
    offer(8'd200, 8'd201, KP_OUTLET);
    random_phase(280);

    write_cell_area(CELL_AREA_W'($urandom_range(2, (1 << CELL_AREA_W) - 2)));
    random_phase(280);
    write_cell_area(CELL_AREA_W'($urandom_range(1, 15)));
    random_phase(280);
    write_cell_area({CELL_AREA_W{1'b1}});
    random_phase(280);
    write_cell_area(CELL_AREA_RESET);
    random_phase(250);

    // Drain everything that is still in flight, then allow a few more cycles
    // for any stray result transaction to show itself.
    cells_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run including the clearing pass.
  initial begin : watchdog
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
